/* rtl/rbs_pkg.sv */
// Shared constants and types for the ray/box slab intersection pipeline.
package rbs_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // quotient magnitude bits, bits retired per divider stage, divider stages
   localparam int DIV_QB   = 31;
   localparam int DIV_BPS  = 2;
   localparam int DIV_ITER = (DIV_QB + DIV_BPS - 1) / DIV_BPS;
   // abs stage + overflow stage + iterations + sign stage
   localparam int DIV_LAT  = DIV_ITER + 3;

   localparam logic [30:0] T_MAX = 31'h7fff_ffff;

   typedef logic signed [31:0] t_type;

   typedef int unsigned axis_list_type [4];
   localparam axis_list_type PAIR_AXES = '{0, 1, 2, 0};

endpackage

/* rtl/rbs_div.sv */
// Pipelined signed fixed-point divider with symmetric saturation to +-(2^31 - 1).
module rbs_div #(
   parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic signed [32:0] num,
   input  logic signed [31:0] den,
   output logic signed [31:0] t
);
   import rbs_pkg::*;

   localparam int NW = (33 + FRAC_BITS > DIV_QB + 32) ? 33 + FRAC_BITS : DIV_QB + 32;

   logic [32:0] mn_ff, mn_in;
   logic [31:0] md_ff, md_in;
   logic        na_ff, na_in;

   logic [NW-1:0]     r_ff [DIV_ITER+1];
   logic [31:0]       d_ff [DIV_ITER+1];
   logic [DIV_QB-1:0] q_ff [DIV_ITER+1];
   logic              ng_ff [DIV_ITER+1];
   logic              ov_ff [DIV_ITER+1];

   logic [NW-1:0] n_in;
   logic          ov_in;
   logic [DIV_QB-1:0] tq;
   t_type         t_ff, t_in;

   always_comb begin
      mn_in = num[32] ? (~num[32:0] + 33'd1) : num[32:0];
      md_in = den[31] ? (~den + 32'd1) : den;
      na_in = num[32] ^ den[31];
   end

   always_ff @(posedge clock) begin
      mn_ff <= mn_in;
      md_ff <= md_in;
      na_ff <= na_in;
   end

   always_comb begin
      n_in  = NW'(mn_ff) << FRAC_BITS;
      ov_in = n_in >= (NW'(md_ff) << DIV_QB);
   end

   always_ff @(posedge clock) begin
      r_ff[0]  <= n_in;
      d_ff[0]  <= md_ff;
      q_ff[0]  <= '0;
      ng_ff[0] <= na_ff;
      ov_ff[0] <= ov_in;
   end

   for (genvar s = 0; s < DIV_ITER; s++) begin : g_iter
      logic [NW-1:0]     r_in;
      logic [DIV_QB-1:0] q_in;

      always_comb begin
         logic [NW-1:0] sh;
         int            idx;
         r_in = r_ff[s];
         q_in = q_ff[s];
         for (int k = 0; k < DIV_BPS; k++) begin
            idx = DIV_QB - 1 - s * DIV_BPS - k;
            if (idx >= 0) begin
               sh = NW'(d_ff[s]) << idx;
               if (r_in >= sh) begin
                  r_in      = r_in - sh;
                  q_in[idx] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         r_ff[s+1]  <= r_in;
         d_ff[s+1]  <= d_ff[s];
         q_ff[s+1]  <= q_in;
         ng_ff[s+1] <= ng_ff[s];
         ov_ff[s+1] <= ov_ff[s];
      end
   end

   always_comb begin
      tq   = ov_ff[DIV_ITER] ? T_MAX : q_ff[DIV_ITER];
      t_in = ng_ff[DIV_ITER] ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
   end

   assign t = t_ff;

endmodule

/* rtl/ray_box_slab_intersect.sv */
// Top level: fully pipelined ray versus axis-aligned box slab test.
//
//  channel  handshake           words
//  req      start / busy        ray origin, direction, box corners
//  rsp      rsp_valid (strobe)  hit, distance, distance_valid
//
// One word enters per cycle; busy stays low. Each result is computed by
// the six parallel pipelined dividers (two quotient bits per stage) between
// an input register and two compare registers. Reset clears the valid
// chain only. The receiver cannot stall, so the pipeline never holds.
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic        [30:0] rsp_distance,
   output logic               rsp_distance_valid
);
   import rbs_pkg::*;

   localparam int LAT = DIV_LAT + 3;

   logic [LAT-1:0] vld_ff, vld_in;
   logic [2:0]     live_ff [DIV_LAT+2];

   logic signed [32:0] n0_ff [3];
   logic signed [32:0] n1_ff [3];
   logic signed [31:0] dn_ff [3];
   t_type              t0 [3];
   t_type              t1 [3];

   t_type       lo_ff [3], lo_in [3];
   t_type       hi_ff [3], hi_in [3];
   logic [30:0] c_ff [3], c_in [3];
   logic [2:0]  cv_ff, cv_in;

   logic        hit_ff, hit_in;
   logic [30:0] dist_ff, dist_in;
   logic        dv_ff, dv_in;

   logic signed [31:0] org [3];
   logic signed [31:0] dr  [3];
   logic signed [31:0] bmn [3];
   logic signed [31:0] bmx [3];

   assign busy = 1'b0;

   assign org = '{req_origin_x, req_origin_y, req_origin_z};
   assign dr  = '{req_dir_x, req_dir_y, req_dir_z};
   assign bmn = '{req_box_min_x, req_box_min_y, req_box_min_z};
   assign bmx = '{req_box_max_x, req_box_max_y, req_box_max_z};

   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         n0_ff[a] <= 33'(bmn[a]) - 33'(org[a]);
         n1_ff[a] <= 33'(bmx[a]) - 33'(org[a]);
         dn_ff[a] <= dr[a];
      end
      live_ff[0] <= {dr[2] != 0, dr[1] != 0, dr[0] != 0};
      for (int s = 1; s < DIV_LAT + 2; s++) begin
         live_ff[s] <= live_ff[s-1];
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
         .clock (clock),
         .num   (n0_ff[a]),
         .den   (dn_ff[a]),
         .t     (t0[a])
      );
      rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
         .clock (clock),
         .num   (n1_ff[a]),
         .den   (dn_ff[a]),
         .t     (t1[a])
      );
   end

   // per-axis near/far and least positive crossing
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_in[a] = (t0[a] < t1[a]) ? t0[a] : t1[a];
         hi_in[a] = (t0[a] < t1[a]) ? t1[a] : t0[a];
         c_in[a]  = T_MAX;
         cv_in[a] = 1'b0;
         if (t0[a] > 0) begin
            c_in[a]  = t0[a][30:0];
            cv_in[a] = 1'b1;
         end
         if (t1[a] > 0) begin
            cv_in[a] = 1'b1;
            if (t1[a][30:0] < c_in[a]) begin
               c_in[a] = t1[a][30:0];
            end
         end
         cv_in[a] = cv_in[a] & live_ff[DIV_LAT][a];
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      c_ff  <= c_in;
      cv_ff <= cv_in;
   end

   always_comb begin
      logic  miss;
      t_type nr, fr;
      int unsigned p, q;
      miss    = 1'b0;
      dist_in = T_MAX;
      for (int k = 0; k < 3; k++) begin
         p  = PAIR_AXES[k];
         q  = PAIR_AXES[k+1];
         nr = (lo_ff[p] > lo_ff[q]) ? lo_ff[p] : lo_ff[q];
         fr = (hi_ff[p] < hi_ff[q]) ? hi_ff[p] : hi_ff[q];
         if (live_ff[DIV_LAT+1][p] && live_ff[DIV_LAT+1][q] && fr < nr) begin
            miss = 1'b1;
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (cv_ff[a] && c_ff[a] < dist_in) begin
            dist_in = c_ff[a];
         end
      end
      hit_in = ~miss;
      dv_in  = ~miss & (|cv_ff);
      if (miss) begin
         dist_in = T_MAX;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      dist_ff <= dist_in;
      dv_ff   <= dv_in;
   end

   assign rsp_valid          = vld_ff[LAT-1];
   assign rsp_hit            = hit_ff;
   assign rsp_distance       = dist_ff;
   assign rsp_distance_valid = dv_ff;

   a_dv_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance_valid |-> rsp_hit)
      else $error("distance valid without hit");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_distance_valid |-> rsp_distance == T_MAX)
      else $error("distance not saturated");

   a_parallel: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_dir_x == 0 && req_dir_y == 0 && req_dir_z == 0
      |-> ##LAT (rsp_valid && rsp_hit && !rsp_distance_valid))
      else $error("all-parallel ray must hit with no distance");

endmodule

/* tb/tb_ray_box_slab_intersect.sv */
// Testbench for ray_box_slab_intersect: directed and random ray/box words checked against a predictor.
`timescale 1ns / 1ps
module tb_ray_box_slab_intersect;
   import rbs_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int WATCHDOG = 2000;

   typedef struct packed {
      logic hit;
      logic [30:0] distance;
      logic distance_valid;
   } slab_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   t_type req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   t_type req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   t_type req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   t_type req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic rsp_valid, rsp_hit, rsp_distance_valid;
   logic [30:0] rsp_distance;

   slab_result_type expected_hits[$];
   int errors = 0;
   int idle_cycles = 0;

   ray_box_slab_intersect dut (.*);

   initial forever #4 clock = ~clock;

   function automatic longint slab_crossing(longint bound, longint org, longint d);
      longint num;
      longint unsigned mn, md, q;
      num = bound - org;
      mn = (num < 0) ? -num : num;
      md = (d < 0) ? -d : d;
      q = (mn << FB) / md;
      if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
      return ((num < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic slab_result_type predict_slab(t_type o[3], t_type d[3],
                                                    t_type lo[3], t_type hi[3]);
      longint t0[3], t1[3], nr, fr, best_t;
      bit miss, valid;
      int p, q;
      slab_result_type r;
      miss = 0; valid = 0; best_t = 64'h7fff_ffff;
      for (int a = 0; a < 3; a++) begin
         t0[a] = 0; t1[a] = 0;
         if (d[a] != 0) begin
            t0[a] = slab_crossing(lo[a], o[a], d[a]);
            t1[a] = slab_crossing(hi[a], o[a], d[a]);
         end
      end
      for (int a = 0; a < 3; a++) begin
         p = PAIR_AXES[a]; q = PAIR_AXES[a + 1];
         if (d[p] == 0 || d[q] == 0) continue;
         nr = (t0[p] < t1[p]) ? t0[p] : t1[p];
         fr = (t0[q] < t1[q]) ? t0[q] : t1[q];
         if (fr > nr) nr = fr;
         fr = (t0[p] > t1[p]) ? t0[p] : t1[p];
         if (((t0[q] > t1[q]) ? t0[q] : t1[q]) < fr) fr = (t0[q] > t1[q]) ? t0[q] : t1[q];
         if (fr < nr) miss = 1;
      end
      if (!miss)
         for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) continue;
            if (t0[a] > 0) begin valid = 1; if (t0[a] < best_t) best_t = t0[a]; end
            if (t1[a] > 0) begin valid = 1; if (t1[a] < best_t) best_t = t1[a]; end
         end
      r.hit = !miss;
      r.distance = miss ? T_MAX : best_t[30:0];
      r.distance_valid = !miss && valid;
      return r;
   endfunction

   task automatic send_ray(t_type o[3], t_type d[3], t_type lo[3], t_type hi[3]);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 1)) gap = 0;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_origin_x <= o[0]; req_origin_y <= o[1]; req_origin_z <= o[2];
      req_dir_x <= d[0]; req_dir_y <= d[1]; req_dir_z <= d[2];
      req_box_min_x <= lo[0]; req_box_min_y <= lo[1]; req_box_min_z <= lo[2];
      req_box_max_x <= hi[0]; req_box_max_y <= hi[1]; req_box_max_z <= hi[2];
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_hits.push_back(predict_slab(o, d, lo, hi));
   endtask

   function automatic t_type rand_word(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 2000)) - 1000;
         2: return ($signed($urandom_range(0, 200)) - 100) <<< FB;
         default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      endcase
   endfunction

   task automatic test_directed();
      t_type o[3], d[3], lo[3], hi[3];
      t_type ext[4] = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sh1};
      // unit box from outside along +x, axis-parallel y/z
      o = '{-(5 <<< FB), 0, 0}; d = '{1 <<< FB, 0, 0};
      lo = '{-(1 <<< FB), -(1 <<< FB), -(1 <<< FB)}; hi = '{1 <<< FB, 1 <<< FB, 1 <<< FB};
      send_ray(o, d, lo, hi);
      // all directions zero
      d = '{0, 0, 0}; send_ray(o, d, lo, hi);
      // diagonal miss
      o = '{-(5 <<< FB), 5 <<< FB, 0}; d = '{1 <<< FB, 1 <<< FB, 1}; send_ray(o, d, lo, hi);
      // origin inside, mixed-sign direction
      o = '{0, 0, 0}; d = '{-(1 <<< FB), -(2 <<< FB), 3 <<< FB}; send_ray(o, d, lo, hi);
      // tiny crossing truncating to zero, huge direction
      o = '{0, 0, 0}; d = '{32'sh7fff_ffff, 0, 0}; lo = '{-1, 0, 0}; hi = '{1, 0, 0};
      send_ray(o, d, lo, hi);
      // box behind the ray: hit with no positive crossing
      o = '{5 <<< FB, 0, 0}; d = '{1 <<< FB, 0, 0};
      lo = '{-(1 <<< FB), 0, 0}; hi = '{1 <<< FB, 0, 0}; send_ray(o, d, lo, hi);
      // inverted box
      o = '{0, 0, 0}; d = '{1 <<< FB, 1 <<< FB, 1 <<< FB};
      lo = '{3 <<< FB, 3 <<< FB, 3 <<< FB}; hi = '{2 <<< FB, 2 <<< FB, 2 <<< FB};
      send_ray(o, d, lo, hi);
      // saturation: extreme operands, tiny or extreme direction
      for (int i = 0; i < 16; i++) begin
         for (int a = 0; a < 3; a++) begin
            o[a] = ext[(i + a) % 4]; lo[a] = ext[(i / 4 + a) % 4];
            hi[a] = ext[(i + 2 * a + 1) % 4];
            d[a] = (i % 2) ? ext[(i + a) % 2] : ((a == i % 3) ? -1 : 1);
         end
         send_ray(o, d, lo, hi);
      end
   endtask

   task automatic test_random(int count);
      t_type o[3], d[3], lo[3], hi[3];
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         for (int a = 0; a < 3; a++) begin
            if (mode < 6) begin
               // well-formed box around a small region, ray origin drawn from the same range
               lo[a] = rand_word(2);
               hi[a] = lo[a] + ($signed($urandom_range(0, 20)) <<< FB);
               o[a] = rand_word(2);
               d[a] = ($urandom_range(0, 5) == 0) ? 0 : rand_word($urandom_range(1, 2));
            end else begin
               o[a] = rand_word($urandom_range(0, 3));
               d[a] = ($urandom_range(0, 7) == 0) ? 0 : rand_word($urandom_range(0, 3));
               lo[a] = rand_word($urandom_range(0, 3));
               hi[a] = rand_word($urandom_range(0, 3));
            end
         end
         send_ray(o, d, lo, hi);
      end
   endtask

   always @(posedge clock) begin
      slab_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_hits.pop_front();
            if (rsp_hit !== e.hit) begin
               $error("hit: expected %0d actual %0d", e.hit, rsp_hit); errors++;
            end
            if (rsp_distance !== e.distance) begin
               $error("distance: expected %0d actual %0d", e.distance, rsp_distance);
               errors++;
            end
            if (rsp_distance_valid !== e.distance_valid) begin
               $error("distance_valid: expected %0d actual %0d", e.distance_valid,
                      rsp_distance_valid);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("ray_box_slab_intersect: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1330);
      start <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DIV_LAT + 8) @(posedge clock);
      if (errors == 0 && expected_hits.size() == 0)
         $display("ray_box_slab_intersect: match");
      else
         $display("ray_box_slab_intersect: mismatch");
      $finish;
   end
endmodule
